[rtl/wc35_pkg.sv]
// Shared types, constants and helpers of the 3x3 / 5x5 window convolution unit.
// Depends on nothing; every other file of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none
package wc35_pkg;

	localparam int PIX_W       = 16;
	localparam int COEFF_W     = 16;
	localparam int WIN_SIZE    = 25;
	localparam int NUM_COEFF   = 25;
	localparam int NUM_LINES   = 4;
	localparam int NUM_GROUPS  = 6;
	localparam int GROUP_SLOTS = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int LWIDTH_W    = 11;
	localparam int CTRL_W      = 34;
	localparam int MIN_WIDTH   = 5;
	localparam int ROW_W       = 3;
	localparam int JQ_DEPTH    = 4;
	localparam int JQ_CNT_W    = $clog2(JQ_DEPTH + 1);

	// Window layouts: single modes shift by five taps, dual mode by six.
	localparam int SINGLE_STRIDE = 5;
	localparam int SINGLE_COLS   = 5;
	localparam int DUAL_STRIDE   = 6;
	localparam int DUAL_COLS     = 3;
	localparam int KERNEL3_TAPS  = 9;

	localparam int PROD_W = 32;
	localparam int PART_W = 35;
	localparam int ACC_W  = 38;

	localparam logic [1:0] MODE_5X5   = 2'd0;
	localparam logic [1:0] MODE_3X3   = 2'd1;
	localparam logic [1:0] MODE_DUAL  = 2'd2;
	localparam logic [1:0] MODE_STORE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CTRL  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd7;

	typedef logic signed [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [NUM_COEFF-1:0][COEFF_W-1:0] coeff;
		logic [PIX_W-1:0]                  bias;
		logic [1:0]                        mode;
		logic [LWIDTH_W-1:0]               line_width;
	} cfg_t;

	typedef struct packed {
		logic [WIN_SIZE-1:0][PIX_W-1:0] win;
		logic                           row_end;
	} job_t;

	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] value;
		logic             row_end;
		logic             sat;
	} result_t;

	function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
		logic [ROW_W-1:0] res;
		res = (r == {ROW_W{1'b1}}) ? r : r + ROW_W'(1);
		return res;
	endfunction

endpackage
`default_nettype wire

[rtl/wc35_job_queue.sv]
// Short queue of window snapshots between the front end and the MAC back end.
// Depends on wc35_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none
module wc35_job_queue import wc35_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  job_t                     din,
	input  wire logic                pop,
	output job_t                     dout,
	output logic                     valid,
	output logic [JQ_CNT_W-1:0]      count
);
	localparam int PW = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;

	job_t             mem_q [JQ_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [JQ_CNT_W-1:0] count_q;
	logic             do_pop;

	assign valid  = (count_q != '0);
	assign do_pop = pop && valid;
	assign dout   = mem_q[rd_ptr_q];
	assign count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(JQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(JQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + JQ_CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - JQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

[rtl/wc35_front.sv]
// Front end: pixel intake, row and column tracking, line stores and sliding window.
// Depends on wc35_pkg; feeds window snapshots into wc35_job_queue.
`timescale 1ns / 1ps
`default_nettype none
module wc35_front import wc35_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  cfg_t                     cfg,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [PIX_W-1:0]    pixel_a,
	input  wire logic [PIX_W-1:0]    pixel_b,
	input  wire logic                first_pixel,
	input  wire logic [JQ_CNT_W-1:0] jq_count,
	output logic                     job_push,
	output job_t                     job
);
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > LWIDTH_W) ? WW : LWIDTH_W;

	logic [EW-1:0] lw_ext, w_sel;
	logic [WW-1:0] w_eff;
	logic [CW-1:0] col_q, col0, c, col_d;
	logic [ROW_W-1:0] row_q, row0, row1, row_d, k_last;
	logic [WW-1:0] cn;
	logic wrap0, wrap1, emit, row_end, accept, dual;

	logic valid_s1, emit_s1, row_end_s1, fwd_q;
	logic [CW-1:0] c_s1;
	logic [PIX_W-1:0] pa_s1, pb_s1;
	logic [PIX_W-1:0] line_mem [NUM_LINES][MAX_WIDTH];
	logic [NUM_LINES-1:0][PIX_W-1:0] rd_q, wd_q, rd_eff, wdata;
	logic [DUAL_STRIDE-1:0][PIX_W-1:0] v;
	logic [WIN_SIZE-1:0][PIX_W-1:0] win_q, win_d;

	assign dual = (cfg.mode == MODE_DUAL);

	always_comb begin
		lw_ext = EW'(cfg.line_width);
		if (lw_ext < EW'(MIN_WIDTH)) begin
			w_sel = EW'(MIN_WIDTH);
		end else if (lw_ext > EW'(MAX_WIDTH)) begin
			w_sel = EW'(MAX_WIDTH);
		end else begin
			w_sel = lw_ext;
		end
		w_eff = WW'(w_sel);
	end

	// Position of the incoming pixel and the counters after it.
	always_comb begin
		col0   = first_pixel ? '0 : col_q;
		row0   = first_pixel ? '0 : row_q;
		wrap0  = (WW'(col0) >= w_eff);
		c      = wrap0 ? '0 : col0;
		row1   = wrap0 ? row_inc(row0) : row0;
		k_last = (cfg.mode == MODE_3X3 || cfg.mode == MODE_DUAL) ? ROW_W'(2) : ROW_W'(4);
		emit   = (cfg.mode != MODE_STORE) && (row1 >= k_last) && (WW'(c) >= WW'(k_last));
		row_end = (WW'(c) == w_eff - WW'(1));
		cn     = WW'(c) + WW'(1);
		wrap1  = (cn >= w_eff);
		col_d  = wrap1 ? '0 : CW'(cn);
		row_d  = wrap1 ? row_inc(row1) : row1;
	end

	// Room is checked against the queue plus the snapshot about to enter it.
	assign full = ((JQ_CNT_W + 1)'(jq_count) + (JQ_CNT_W + 1)'(valid_s1 && emit_s1))
		>= (JQ_CNT_W + 1)'(JQ_DEPTH);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
			win_q    <= '0;
		end else begin
			valid_s1 <= accept;
			fwd_q    <= accept && valid_s1 && (c == c_s1);
			if (accept) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (valid_s1) begin
				win_q <= win_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		wd_q <= wdata;
		if (accept) begin
			c_s1       <= c;
			pa_s1      <= pixel_a;
			pb_s1      <= pixel_b;
			emit_s1    <= emit;
			row_end_s1 <= row_end;
		end
	end

	// Line stores: read at intake, written back in the cycle after.
	always_ff @(posedge clk) begin
		for (int b = 0; b < NUM_LINES; b++) begin
			if (accept) begin
				rd_q[b] <= line_mem[b][c];
			end
			if (valid_s1) begin
				line_mem[b][c_s1] <= wdata[b];
			end
		end
	end

	always_comb begin
		// A write to the same column in the cycle of the read is forwarded.
		rd_eff   = fwd_q ? wd_q : rd_q;
		wdata[0] = pa_s1;
		wdata[1] = rd_eff[0];
		wdata[2] = dual ? pb_s1 : rd_eff[1];
		wdata[3] = rd_eff[2];
		v = '0;
		if (dual) begin
			v[0] = rd_eff[1];
			v[1] = rd_eff[0];
			v[2] = pa_s1;
			v[3] = rd_eff[3];
			v[4] = rd_eff[2];
			v[5] = pb_s1;
		end else begin
			v[0] = rd_eff[3];
			v[1] = rd_eff[2];
			v[2] = rd_eff[1];
			v[3] = rd_eff[0];
			v[4] = pa_s1;
		end
	end

	always_comb begin
		win_d = win_q;
		if (dual) begin
			for (int k = 0; k < (DUAL_COLS - 1) * DUAL_STRIDE; k++) begin
				win_d[k] = win_q[k + DUAL_STRIDE];
			end
			for (int r = 0; r < DUAL_STRIDE; r++) begin
				win_d[(DUAL_COLS - 1) * DUAL_STRIDE + r] = v[r];
			end
		end else begin
			for (int k = 0; k < (SINGLE_COLS - 1) * SINGLE_STRIDE; k++) begin
				win_d[k] = win_q[k + SINGLE_STRIDE];
			end
			for (int r = 0; r < SINGLE_STRIDE; r++) begin
				win_d[(SINGLE_COLS - 1) * SINGLE_STRIDE + r] = v[r];
			end
		end
	end

	assign job_push    = valid_s1 && emit_s1;
	assign job.win     = win_d;
	assign job.row_end = row_end_s1;

endmodule
`default_nettype wire

[rtl/wc35_mac.sv]
// Back end: 25 multiplier lanes, registered adder tree, rounding and saturation.
// Depends on wc35_pkg; takes window snapshots from wc35_job_queue.
`timescale 1ns / 1ps
`default_nettype none
module wc35_mac import wc35_pkg::*; #(
	parameter int COEFF_FRAC_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  job_t      job,
	input  wire logic job_valid,
	output logic      job_pop,
	input  wire logic pop,
	output result_t   res
);
	localparam logic signed [ACC_W-1:0] ROUND = (ACC_W'(1) << COEFF_FRAC_BITS) >>> 1;
	localparam int NPART = WIN_SIZE / SINGLE_STRIDE;

	logic adv;
	logic v_s1, v_s2, v_s3, re_s1, re_s2, re_s3;
	logic signed [PROD_W-1:0] prod_d [WIN_SIZE];
	logic signed [PROD_W-1:0] prod_s1 [WIN_SIZE];
	logic signed [PART_W-1:0] part_d [NPART];
	logic signed [PART_W-1:0] part_s2 [NPART];
	logic signed [ACC_W-1:0] acc_d, acc_s3, shifted;
	logic res_valid_q, res_row_end_q, res_sat_q;
	logic [PIX_W-1:0] res_value_q;

	// The whole back end moves together whenever the result slot frees up.
	assign adv     = !res_valid_q || pop;
	assign job_pop = adv && job_valid;

	for (genvar n = 0; n < WIN_SIZE; n++) begin : g_lane
		localparam int I5 = (n % 5) * 5 + n / 5;
		localparam int I3 = (n < KERNEL3_TAPS) ? ((n % 3) + 2) * 5 + n / 3 + 2 : 0;
		localparam int M  = (n < KERNEL3_TAPS) ? n : n - KERNEL3_TAPS;
		localparam int ID = (n < 2 * KERNEL3_TAPS)
			? (M % 3) * 6 + ((n < KERNEL3_TAPS) ? 0 : 3) + M / 3 : 0;
		logic signed [PIX_W-1:0]   pix_sel;
		logic signed [COEFF_W-1:0] coef_s;

		always_comb begin
			coef_s = cfg.coeff[n];
			case (cfg.mode)
				MODE_5X5:  pix_sel = job.win[I5];
				MODE_3X3:  pix_sel = (n < KERNEL3_TAPS) ? job.win[I3] : '0;
				MODE_DUAL: pix_sel = (n < 2 * KERNEL3_TAPS) ? job.win[ID] : '0;
				default:   pix_sel = '0;
			endcase
			prod_d[n] = pix_sel * coef_s;
		end
	end

	always_comb begin
		for (int g = 0; g < NPART; g++) begin
			part_d[g] = '0;
			for (int j = 0; j < SINGLE_STRIDE; j++) begin
				part_d[g] = part_d[g] + PART_W'(prod_s1[g * SINGLE_STRIDE + j]);
			end
		end
		acc_d = (ACC_W'(signed'(cfg.bias)) <<< COEFF_FRAC_BITS) + ROUND;
		for (int g = 0; g < NPART; g++) begin
			acc_d = acc_d + ACC_W'(part_s2[g]);
		end
		shifted = acc_s3 >>> COEFF_FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= job_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_d;
			re_s1   <= job.row_end;
			part_s2 <= part_d;
			re_s2   <= re_s1;
			acc_s3  <= acc_d;
			re_s3   <= re_s2;
			res_row_end_q <= re_s3;
			if (shifted > ACC_W'(32767)) begin
				res_value_q <= 16'h7FFF;
				res_sat_q   <= 1'b1;
			end else if (shifted < -ACC_W'(32768)) begin
				res_value_q <= 16'h8000;
				res_sat_q   <= 1'b1;
			end else begin
				res_value_q <= shifted[PIX_W-1:0];
				res_sat_q   <= 1'b0;
			end
		end
	end

	assign res.valid   = res_valid_q;
	assign res.value   = res_value_q;
	assign res.row_end = res_row_end_q;
	assign res.sat     = res_sat_q;

endmodule
`default_nettype wire

[rtl/window_convolution_3x3_5x5_unit.sv]
// Top level of the 3x3 / 5x5 window convolution unit: register file and channel wiring.
// Depends on wc35_pkg, wc35_front, wc35_job_queue and wc35_mac.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Direction  Handshake           Payload
// pixels    in         push / full         pixel_a, pixel_b, first_pixel
// results   out        empty / pop         conv_value, row_end, saturated
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One pixel request is taken every clock while full is low; the line stores are read at intake and
// written in the cycle after, and that single read/write port per line sets the rate.
// A result is ready once its pixel has passed the registered front stage, then the job queue,
// the multiply, two adder-tree stages and the rounding/saturating output register, each of
// them registered.
// Reset clears counters, window, valid flags and configuration registers; line stores need no clearing pass.
// When results are not popped the back end holds, the job queue fills, and full rises.
//
module window_convolution_3x3_5x5_unit import wc35_pkg::*; #(
	parameter int MAX_WIDTH       = 1024,
	parameter int COEFF_FRAC_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [PIX_W-1:0]      pixel_a,
	input  wire logic [PIX_W-1:0]      pixel_b,
	input  wire logic                  first_pixel,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [PIX_W-1:0]           conv_value,
	output logic                       row_end,
	output logic                       saturated,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	logic [CFG_DATA_W-1:0] coeff_grp_q [NUM_GROUPS];
	logic [CTRL_W-1:0]     ctrl_q;
	logic [LWIDTH_W-1:0]   width_q;
	cfg_t                  cfg;

	logic                job_push, job_valid, job_pop;
	job_t                job_in, job_out;
	logic [JQ_CNT_W-1:0] jq_count;
	result_t             res;

	// Configuration writes are always accepted.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				coeff_grp_q[g] <= '0;
			end
			ctrl_q  <= '0;
			width_q <= LWIDTH_W'(MIN_WIDTH);
		end else if (cfg_valid) begin
			if (cfg_index == REG_CTRL) begin
				ctrl_q <= cfg_data[CTRL_W-1:0];
			end else if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data[LWIDTH_W-1:0];
			end else begin
				coeff_grp_q[cfg_index] <= cfg_data;
			end
		end
	end

	// Coefficient n sits in group n/4, slot n%4; the last one shares the control word.
	always_comb begin
		for (int n = 0; n < NUM_COEFF - 1; n++) begin
			cfg.coeff[n] = coeff_grp_q[n / GROUP_SLOTS][(n % GROUP_SLOTS) * COEFF_W +: COEFF_W];
		end
		cfg.coeff[NUM_COEFF-1] = ctrl_q[COEFF_W-1:0];
		cfg.bias       = ctrl_q[2*COEFF_W-1:COEFF_W];
		cfg.mode       = ctrl_q[CTRL_W-1:2*COEFF_W];
		cfg.line_width = width_q;
	end

	wc35_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.push       (push),
		.full       (full),
		.pixel_a    (pixel_a),
		.pixel_b    (pixel_b),
		.first_pixel(first_pixel),
		.jq_count   (jq_count),
		.job_push   (job_push),
		.job        (job_in)
	);

	wc35_job_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.din   (job_in),
		.pop   (job_pop),
		.dout  (job_out),
		.valid (job_valid),
		.count (jq_count)
	);

	wc35_mac #(
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.job      (job_out),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.pop      (pop),
		.res      (res)
	);

	assign empty      = !res.valid;
	assign conv_value = res.value;
	assign row_end    = res.row_end;
	assign saturated  = res.sat;

	// The front end must never push a snapshot into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> (jq_count < JQ_CNT_W'(JQ_DEPTH)) || job_pop)
		else $error("job queue overflow");

	// The store-only mode never produces a window snapshot.
	a_store_silent: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> cfg.mode != MODE_STORE)
		else $error("snapshot pushed in store-only mode");

	// The queue count stays within its depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		jq_count <= JQ_CNT_W'(JQ_DEPTH))
		else $error("job queue count out of range");

endmodule
`default_nettype wire
